// ----- hw/rtl/uutp_pkg.sv -----
// uutp_pkg: types, character codes and the hex decode function for the UUID text parser.
// No dependencies; used by uutp_core and uuid_text_parser.
`timescale 1ns / 1ps

package uutp_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FEW     = 2'd1,
    ST_INVALID = 2'd2,
    ST_EXTRA   = 2'd3
  } status_e;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  localparam logic [5:0] DIGITS_NEEDED = 6'd32;

  // prefix window codes
  localparam logic [1:0] PW_FIRST = 2'd0;
  localparam logic [1:0] PW_ZERO  = 2'd1;
  localparam logic [1:0] PW_PAST  = 2'd2;

  localparam logic [15:0] POS16_MAX = 16'hFFFF;

  typedef struct packed {
    logic [63:0] acc_high;
    logic [63:0] acc_low;
    logic [5:0]  digit_count;
    logic        braced_mode;
    logic [1:0]  prefix_window;
    logic        dash_used;
    logic [1:0]  first_error;
    logic [15:0] error_where;
    logic [7:0]  error_byte;
  } parse_st_t;

  localparam parse_st_t PARSE_ST_RESET = '{
    acc_high:      64'd0,
    acc_low:       64'd0,
    digit_count:   6'd0,
    braced_mode:   1'b0,
    prefix_window: PW_FIRST,
    dash_used:     1'b0,
    first_error:   ST_OK,
    error_where:   16'd0,
    error_byte:    8'd0
  };

  typedef struct packed {
    status_e     status;
    logic [63:0] value_high;
    logic [63:0] value_low;
    logic [15:0] error_position;
    logic [7:0]  bad_char;
  } parse_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/uutp_core.sv -----
// uutp_core: next-state and result logic for one character word.
// Depends on uutp_pkg.
`timescale 1ns / 1ps

module uutp_core import uutp_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  parse_st_t              st_i,
  input  logic [POS_WIDTH-1:0]   pos_i,
  input  logic [7:0]             ch_i,
  input  logic                   last_i,
  output parse_st_t              st_o,
  output parse_res_t             res_o
);

  localparam int PW_EXT = (POS_WIDTH > 16) ? POS_WIDTH : 16;

  logic [PW_EXT-1:0] pos_ext;
  logic [15:0]       pos16;
  logic [4:0]        hex;
  logic              is_open, is_close_end;

  assign pos_ext = PW_EXT'(pos_i);
  assign pos16   = (pos_ext > PW_EXT'(POS16_MAX)) ? POS16_MAX : pos_ext[15:0];
  assign hex     = hex_decode(ch_i);
  assign is_open = (pos_i == '0) && (ch_i == CH_LBRACE) && !last_i;
  assign is_close_end = last_i && st_i.braced_mode && (ch_i == CH_RBRACE);

  always_comb begin
    st_o = st_i;
    if (is_open) begin
      st_o.braced_mode = 1'b1;
    end else if (!is_close_end && st_i.first_error == ST_OK) begin
      if (st_i.prefix_window == PW_ZERO && (ch_i == CH_LX || ch_i == CH_UX)) begin
        st_o.digit_count   = 6'd0;
        st_o.acc_high      = 64'd0;
        st_o.acc_low       = 64'd0;
        st_o.prefix_window = PW_PAST;
      end else begin
        if (st_i.prefix_window == PW_FIRST && ch_i == CH_ZERO) begin
          st_o.prefix_window = PW_ZERO;
        end else begin
          st_o.prefix_window = PW_PAST;
        end
        priority if (st_i.digit_count >= DIGITS_NEEDED) begin
          st_o.first_error = ST_EXTRA;
          st_o.error_where = pos16;
        end else if (ch_i == CH_DASH && st_i.digit_count != 6'd0 && !st_i.dash_used) begin
          st_o.dash_used = 1'b1;
        end else if (!hex[4]) begin
          st_o.first_error = ST_INVALID;
          st_o.error_where = pos16;
          st_o.error_byte  = ch_i;
        end else begin
          st_o.acc_high    = {st_i.acc_high[59:0], st_i.acc_low[63:60]};
          st_o.acc_low     = {st_i.acc_low[59:0], hex[3:0]};
          st_o.digit_count = st_i.digit_count + 6'd1;
          st_o.dash_used   = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_o = '{status: ST_OK, value_high: 64'd0, value_low: 64'd0,
              error_position: 16'd0, bad_char: 8'd0};
    priority if (st_o.braced_mode && ch_i != CH_RBRACE) begin
      res_o.status   = ST_INVALID;
      res_o.bad_char = CH_LBRACE;
    end else if (st_o.first_error != ST_OK) begin
      res_o.status         = status_e'(st_o.first_error);
      res_o.error_position = st_o.error_where;
      if (st_o.first_error == ST_INVALID) res_o.bad_char = st_o.error_byte;
    end else if (st_o.digit_count < DIGITS_NEEDED) begin
      res_o.status = ST_FEW;
    end else begin
      res_o.value_high = st_o.acc_high;
      res_o.value_low  = st_o.acc_low;
    end
  end

endmodule

// ----- hw/rtl/uuid_text_parser.sv -----
// uuid_text_parser: top level; input word register, parse state, result register.
// A last character word passes the input word register, then its result is loaded into the result register.
// Throughput: one character word per cycle, stalled only by a held result.
// Reset: asynchronous active low; clears parse state, position and both valid flags.
// Depends on uutp_pkg and uutp_core.
`timescale 1ns / 1ps

module uuid_text_parser import uutp_pkg::*; #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] value_high_o,
  output logic [63:0] value_low_o,
  output logic [15:0] error_position_o,
  output logic [7:0]  bad_char_o
);

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 last_q;
  parse_st_t            st_q, st_d;
  logic [POS_WIDTH-1:0] pos_q;
  parse_res_t           res_d, res_q;
  logic                 out_valid_q;
  logic                 adv, load;

  uutp_core #(.POS_WIDTH(POS_WIDTH)) u_core (
    .st_i   (st_q),
    .pos_i  (pos_q),
    .ch_i   (ch_q),
    .last_i (last_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  assign adv  = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign load = adv && last_q;
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q   <= ch_i;
      last_q <= last_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= PARSE_ST_RESET;
      pos_q <= '0;
    end else if (adv) begin
      if (last_q) begin
        st_q  <= PARSE_ST_RESET;
        pos_q <= '0;
      end else begin
        st_q <= st_d;
        if (pos_q != '1) pos_q <= pos_q + POS_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign value_high_o     = res_q.value_high;
  assign value_low_o      = res_q.value_low;
  assign error_position_o = res_q.error_position;
  assign bad_char_o       = res_q.bad_char;

  a_value_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status != ST_OK |-> res_q.value_high == 64'd0 &&
      res_q.value_low == 64'd0)
    else $error("value nonzero on error status");

  a_ok_no_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.status == ST_OK |-> res_q.error_position == 16'd0 &&
      res_q.bad_char == 8'd0)
    else $error("error fields set on ok status");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.digit_count <= DIGITS_NEEDED)
    else $error("digit count overflow");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && last_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a held result");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> pos_q == '0 && st_q.first_error == ST_OK && st_q.digit_count == 6'd0)
    else $error("state not cleared after last word");

endmodule
